// ===== hdl/protobuf_wire_field_parser_macros.svh =====
// Assertion macros shared by the protobuf wire field parser.
`ifndef PROTOBUF_WIRE_FIELD_PARSER_MACROS_SVH
`define PROTOBUF_WIRE_FIELD_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PWFP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwfp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PWFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwfp assertion failed");

`endif

// ===== hdl/pwfp_pkg.sv =====
// Types and constants of the protobuf wire field parser.
package pwfp_pkg;

    localparam logic [1:0] KIND_SCALAR  = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [63:0] ERR_WIRE_TYPE  = 64'd1;
    localparam logic [63:0] ERR_FIELD_ZERO = 64'd2;
    localparam logic [63:0] ERR_OVERLONG   = 64'd3;
    localparam logic [63:0] ERR_TRUNCATED  = 64'd4;

    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LENGTH  = 3'd2;
    localparam logic [2:0] WT_GROUP_S = 3'd3;
    localparam logic [2:0] WT_GROUP_E = 3'd4;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;

    typedef enum logic [5:0] {
        PH_TAG     = 6'b000001,
        PH_VARINT  = 6'b000010,
        PH_FIXED   = 6'b000100,
        PH_LENGTH  = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_ERROR   = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] field_number;
        logic [2:0]  wire_type;
        logic [63:0] value;
        logic        end_of_buffer;
    } result_t;

endpackage

// ===== hdl/pwfp_if.sv =====
// Valid/ready channel interfaces for the parser's byte input and result output.
interface pwfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last;

    modport source (output valid, output in_byte, output last, input ready);
    modport sink (input valid, input in_byte, input last, output ready);
endinterface

interface pwfp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] field_number;
    logic [2:0]  wire_type;
    logic [63:0] value;
    logic        end_of_buffer;

    modport source (output valid, output kind, output field_number, output wire_type,
                    output value, output end_of_buffer, input ready);
    modport sink (input valid, input kind, input field_number, input wire_type,
                  input value, input end_of_buffer, output ready);
endinterface

// ===== hdl/protobuf_wire_field_parser.sv =====
// Streaming protobuf wire-format field parser, top level.
//
// The byte_in channel carries one byte of an encoded message per item, with
// last marking the final byte of the buffer. The field_out channel carries
// one result item per scalar field, one header per bytes field, one item per
// payload byte, and one error item when the encoding is malformed.
// Each byte is decoded in the cycle it is accepted, and its result is registered
// in the result register, or in the skid register while the receiver stalls.
// One byte is accepted every cycle while the skid register is empty; the decode
// logic updates the field state between the input and the result register.
// A two-entry output stage (result register plus skid register) lets the
// block take one more result item after the receiver stops; ready on
// byte_in drops only while the skid register is full.
// After an error, bytes are consumed without results until the last byte.
// The last byte of a buffer always returns the decoder to its reset state.
// Reset empties the output stage and puts the decoder in the tag state.
`include "protobuf_wire_field_parser_macros.svh"

module protobuf_wire_field_parser (
    input  logic           clk,
    input  logic           rst_n,
    pwfp_in_if.sink        byte_in,
    pwfp_out_if.source     field_out
);

    pwfp_pkg::phase_t  phase_reg, phase_next;
    logic [63:0]       acc_reg, acc_next;
    logic [3:0]        pos_reg, pos_next;
    logic [31:0]       field_reg, field_next;
    logic [2:0]        wt_reg, wt_next;
    logic [63:0]       remain_reg, remain_next;

    pwfp_pkg::result_t out_reg, skid_reg, res;
    logic              out_valid_reg, skid_valid_reg;
    logic              in_fire, res_valid, out_free;

    logic [6:0]        var_shift;
    logic [63:0]       var_acc, fix_acc, tag_value;
    logic              var_long, var_done;
    logic [3:0]        pos_inc;
    logic [7:0]        b;
    logic              last;

    assign b        = byte_in.in_byte;
    assign last     = byte_in.last;
    assign byte_in.ready = !skid_valid_reg;
    assign in_fire  = byte_in.valid && !skid_valid_reg;
    assign out_free = !out_valid_reg || field_out.ready;

    assign pos_inc   = pos_reg + 4'd1;
    assign var_shift = {3'd0, pos_reg} * 7'd7;
    assign var_acc   = acc_reg | ({57'd0, b[6:0]} << var_shift[5:0]);
    assign fix_acc   = acc_reg | ({56'd0, b} << {pos_reg[2:0], 3'b000});
    assign var_long  = (pos_reg >= pwfp_pkg::VARINT_MAX_BYTES)
                     || (b[7] && (pos_inc == pwfp_pkg::VARINT_MAX_BYTES));
    assign var_done  = !var_long && !b[7];
    assign tag_value = var_acc;

    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        pos_next    = pos_reg;
        field_next  = field_reg;
        wt_next     = wt_reg;
        remain_next = remain_reg;
        res_valid   = 1'b0;
        res.kind          = pwfp_pkg::KIND_SCALAR;
        res.field_number  = field_reg;
        res.wire_type     = wt_reg;
        res.value         = var_acc;
        res.end_of_buffer = last;

        case (phase_reg)
            pwfp_pkg::PH_ERROR:
            begin
            end
            pwfp_pkg::PH_VARINT, pwfp_pkg::PH_LENGTH:
            begin
                if (var_long)
                begin
                    phase_next = pwfp_pkg::PH_ERROR;
                    res_valid  = 1'b1;
                    res.kind   = pwfp_pkg::KIND_ERROR;
                    res.value  = pwfp_pkg::ERR_OVERLONG;
                end
                else if (var_done)
                begin
                    acc_next  = '0;
                    pos_next  = '0;
                    res_valid = 1'b1;
                    if (phase_reg == pwfp_pkg::PH_VARINT)
                    begin
                        phase_next = pwfp_pkg::PH_TAG;
                    end
                    else if (var_acc == 64'd0)
                    begin
                        phase_next = pwfp_pkg::PH_TAG;
                        res.kind   = pwfp_pkg::KIND_HEADER;
                    end
                    else if (last)
                    begin
                        phase_next = pwfp_pkg::PH_ERROR;
                        res.kind   = pwfp_pkg::KIND_ERROR;
                        res.value  = pwfp_pkg::ERR_TRUNCATED;
                    end
                    else
                    begin
                        phase_next  = pwfp_pkg::PH_PAYLOAD;
                        remain_next = var_acc;
                        res.kind    = pwfp_pkg::KIND_HEADER;
                    end
                end
                else
                begin
                    acc_next = var_acc;
                    pos_next = pos_inc;
                    if (last)
                    begin
                        phase_next = pwfp_pkg::PH_ERROR;
                        res_valid  = 1'b1;
                        res.kind   = pwfp_pkg::KIND_ERROR;
                        res.value  = pwfp_pkg::ERR_TRUNCATED;
                    end
                end
            end
            pwfp_pkg::PH_FIXED:
            begin
                if (pos_inc >= ((wt_reg == pwfp_pkg::WT_FIXED64) ? 4'd8 : 4'd4))
                begin
                    phase_next = pwfp_pkg::PH_TAG;
                    acc_next   = '0;
                    pos_next   = '0;
                    res_valid  = 1'b1;
                    res.value  = fix_acc;
                end
                else
                begin
                    acc_next = fix_acc;
                    pos_next = pos_inc;
                    if (last)
                    begin
                        phase_next = pwfp_pkg::PH_ERROR;
                        res_valid  = 1'b1;
                        res.kind   = pwfp_pkg::KIND_ERROR;
                        res.value  = pwfp_pkg::ERR_TRUNCATED;
                    end
                end
            end
            pwfp_pkg::PH_PAYLOAD:
            begin
                remain_next = remain_reg - 64'd1;
                res_valid   = 1'b1;
                res.kind    = pwfp_pkg::KIND_PAYLOAD;
                res.value   = {56'd0, b};
                if (remain_reg == 64'd1)
                begin
                    phase_next = pwfp_pkg::PH_TAG;
                end
                else if (last)
                begin
                    phase_next = pwfp_pkg::PH_ERROR;
                    res.kind   = pwfp_pkg::KIND_ERROR;
                    res.value  = pwfp_pkg::ERR_TRUNCATED;
                end
            end
            default:
            begin
                phase_next = pwfp_pkg::PH_TAG;
                if (var_long)
                begin
                    phase_next = pwfp_pkg::PH_ERROR;
                    res_valid  = 1'b1;
                    res.kind   = pwfp_pkg::KIND_ERROR;
                    res.value  = pwfp_pkg::ERR_OVERLONG;
                end
                else if (var_done)
                begin
                    acc_next         = '0;
                    pos_next         = '0;
                    wt_next          = tag_value[2:0];
                    field_next       = tag_value[34:3];
                    res.wire_type    = tag_value[2:0];
                    res.field_number = tag_value[34:3];
                    res.kind         = pwfp_pkg::KIND_ERROR;
                    if (tag_value[2:0] == pwfp_pkg::WT_GROUP_S
                        || tag_value[2:0] == pwfp_pkg::WT_GROUP_E
                        || tag_value[2:0] > pwfp_pkg::WT_FIXED32)
                    begin
                        phase_next = pwfp_pkg::PH_ERROR;
                        res_valid  = 1'b1;
                        res.value  = pwfp_pkg::ERR_WIRE_TYPE;
                    end
                    else if (tag_value[34:3] == 32'd0)
                    begin
                        phase_next = pwfp_pkg::PH_ERROR;
                        res_valid  = 1'b1;
                        res.value  = pwfp_pkg::ERR_FIELD_ZERO;
                    end
                    else if (last)
                    begin
                        phase_next = pwfp_pkg::PH_ERROR;
                        res_valid  = 1'b1;
                        res.value  = pwfp_pkg::ERR_TRUNCATED;
                    end
                    else if (tag_value[2:0] == pwfp_pkg::WT_VARINT)
                    begin
                        phase_next = pwfp_pkg::PH_VARINT;
                    end
                    else if (tag_value[2:0] == pwfp_pkg::WT_LENGTH)
                    begin
                        phase_next = pwfp_pkg::PH_LENGTH;
                    end
                    else
                    begin
                        phase_next = pwfp_pkg::PH_FIXED;
                    end
                end
                else
                begin
                    acc_next = var_acc;
                    pos_next = pos_inc;
                    if (last)
                    begin
                        phase_next = pwfp_pkg::PH_ERROR;
                        res_valid  = 1'b1;
                        res.kind   = pwfp_pkg::KIND_ERROR;
                        res.value  = pwfp_pkg::ERR_TRUNCATED;
                    end
                end
            end
        endcase

        if (last)
        begin
            phase_next  = pwfp_pkg::PH_TAG;
            acc_next    = '0;
            pos_next    = '0;
            field_next  = '0;
            wt_next     = '0;
            remain_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= pwfp_pkg::PH_TAG;
            acc_reg    <= '0;
            pos_reg    <= '0;
            field_reg  <= '0;
            wt_reg     <= '0;
            remain_reg <= '0;
        end
        else if (in_fire)
        begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            pos_reg    <= pos_next;
            field_reg  <= field_next;
            wt_reg     <= wt_next;
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || (in_fire && res_valid);
            skid_valid_reg <= skid_valid_reg && in_fire && res_valid;
        end
        else if (in_fire && res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg  <= skid_reg;
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
        else if (in_fire && res_valid)
        begin
            skid_reg <= res;
        end
    end

    assign field_out.valid         = out_valid_reg;
    assign field_out.kind          = out_reg.kind;
    assign field_out.field_number  = out_reg.field_number;
    assign field_out.wire_type     = out_reg.wire_type;
    assign field_out.value         = out_reg.value;
    assign field_out.end_of_buffer = out_reg.end_of_buffer;

    `PWFP_ASSERT_SAME(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `PWFP_ASSERT_NEXT(a_last_clears, clk, rst_n, in_fire && last,
                      phase_reg == pwfp_pkg::PH_TAG && pos_reg == 4'd0 && acc_reg == 64'd0)
    `PWFP_ASSERT_SAME(a_pos_bound, clk, rst_n, 1'b1, pos_reg < pwfp_pkg::VARINT_MAX_BYTES)

endmodule

// ===== dv/protobuf_wire_field_parser_tb.sv =====
// Self-checking testbench for the protobuf wire field parser: directed table, random messages.
`timescale 1ns / 1ps

module protobuf_wire_field_parser_tb;

    localparam int DIRECTED_ROWS = 29;
    localparam int RANDOM_ITEMS  = 550;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int DRAIN_CYCLES  = 20;

    typedef enum logic [1:0] {
        VI_MORE,
        VI_DONE,
        VI_LONG
    } varint_status_t;

    typedef struct packed {
        logic [7:0]         data;
        logic               lst;
        logic               typed;
        pwfp_pkg::result_t  want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pwfp_in_if  byte_if ();
    pwfp_out_if field_if ();

    protobuf_wire_field_parser DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_if),
        .field_out (field_if)
    );

    always #5 clk = ~clk;

    // Decoder state mirrored by the testbench.
    pwfp_pkg::phase_t  dec_phase;
    logic [63:0]       dec_acc;
    logic [3:0]        dec_pos;
    logic [31:0]       dec_field;
    logic [2:0]        dec_wt;
    logic [63:0]       dec_remaining;
    logic              dec_err;

    pwfp_pkg::result_t expected_fields[$];
    logic [7:0]        msg_bytes[$];
    int                mismatches = 0;
    int                decoded_items = 0;
    int                cycle_count = 0;
    int unsigned       rx_hold = 0;
    bit                quiet = 1'b0;

    stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        '{8'h09, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b1, '{pwfp_pkg::KIND_SCALAR, 32'd1, pwfp_pkg::WT_FIXED64,
                               64'hFFFF_FFFF_FFFF_FFFF, 1'b0}},
        '{8'h12, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b1, '{pwfp_pkg::KIND_HEADER, 32'd2, pwfp_pkg::WT_LENGTH,
                               64'd0, 1'b0}},
        '{8'h2D, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h80, 1'b1, 1'b0, '0},
        '{8'h0B, 1'b1, 1'b1, '{pwfp_pkg::KIND_ERROR, 32'd1, pwfp_pkg::WT_GROUP_S,
                               pwfp_pkg::ERR_WIRE_TYPE, 1'b1}},
        '{8'h00, 1'b1, 1'b1, '{pwfp_pkg::KIND_ERROR, 32'd0, pwfp_pkg::WT_VARINT,
                               pwfp_pkg::ERR_FIELD_ZERO, 1'b1}},
        '{8'h08, 1'b1, 1'b1, '{pwfp_pkg::KIND_ERROR, 32'd1, pwfp_pkg::WT_VARINT,
                               pwfp_pkg::ERR_TRUNCATED, 1'b1}},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b1, '{pwfp_pkg::KIND_ERROR, 32'd0, pwfp_pkg::WT_VARINT,
                               pwfp_pkg::ERR_OVERLONG, 1'b1}}
    };

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned pick_pad();
        if ($urandom_range(0, 7) == 0)
        begin
            return $urandom_range(1, 9);
        end
        return 0;
    endfunction

    task automatic append_byte(input logic [7:0] b);
        msg_bytes.insert(msg_bytes.size(), b);
    endtask

    task automatic queue_expected(input pwfp_pkg::result_t r);
        expected_fields.insert(expected_fields.size(), r);
    endtask

    task automatic clear_decoder();
        dec_phase     = pwfp_pkg::PH_TAG;
        dec_acc       = '0;
        dec_pos       = '0;
        dec_field     = '0;
        dec_wt        = '0;
        dec_remaining = '0;
        dec_err       = 1'b0;
    endtask

    function automatic pwfp_pkg::result_t make_result(input logic [1:0] kind,
                                                      input logic [63:0] value,
                                                      input logic lst);
        pwfp_pkg::result_t r;
        r.kind          = kind;
        r.field_number  = dec_field;
        r.wire_type     = dec_wt;
        r.value         = value;
        r.end_of_buffer = lst;
        return r;
    endfunction

    task automatic raise_error(input logic [63:0] code, input logic lst, output bit emit,
                               output pwfp_pkg::result_t res);
        dec_err   = 1'b1;
        dec_phase = pwfp_pkg::PH_ERROR;
        emit      = 1'b1;
        res       = make_result(pwfp_pkg::KIND_ERROR, code, lst);
    endtask

    task automatic varint_step(input logic [7:0] b, output varint_status_t st);
        if (dec_pos > 4'd9)
        begin
            st = VI_LONG;
        end
        else
        begin
            dec_acc = dec_acc | ({57'd0, b[6:0]} << (dec_pos * 7));
            if (!b[7])
            begin
                st = VI_DONE;
            end
            else
            begin
                dec_pos = dec_pos + 4'd1;
                st = (dec_pos >= pwfp_pkg::VARINT_MAX_BYTES) ? VI_LONG : VI_MORE;
            end
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic lst, output bit emit,
                               output pwfp_pkg::result_t res);
        varint_status_t st;
        logic [63:0]    v;
        emit = 1'b0;
        res  = '0;
        if (!dec_err && dec_phase != pwfp_pkg::PH_ERROR)
        begin
            case (dec_phase)
                pwfp_pkg::PH_VARINT:
                begin
                    varint_step(b, st);
                    if (st == VI_LONG)
                    begin
                        raise_error(pwfp_pkg::ERR_OVERLONG, lst, emit, res);
                    end
                    else if (st == VI_DONE)
                    begin
                        v = dec_acc;
                        dec_acc = '0;
                        dec_pos = '0;
                        dec_phase = pwfp_pkg::PH_TAG;
                        emit = 1'b1;
                        res = make_result(pwfp_pkg::KIND_SCALAR, v, lst);
                    end
                    else if (lst)
                    begin
                        raise_error(pwfp_pkg::ERR_TRUNCATED, lst, emit, res);
                    end
                end
                pwfp_pkg::PH_FIXED:
                begin
                    dec_acc = dec_acc | ({56'd0, b} << (dec_pos[2:0] * 8));
                    dec_pos = dec_pos + 4'd1;
                    if (dec_pos >= ((dec_wt == pwfp_pkg::WT_FIXED64) ? 4'd8 : 4'd4))
                    begin
                        v = dec_acc;
                        dec_acc = '0;
                        dec_pos = '0;
                        dec_phase = pwfp_pkg::PH_TAG;
                        emit = 1'b1;
                        res = make_result(pwfp_pkg::KIND_SCALAR, v, lst);
                    end
                    else if (lst)
                    begin
                        raise_error(pwfp_pkg::ERR_TRUNCATED, lst, emit, res);
                    end
                end
                pwfp_pkg::PH_LENGTH:
                begin
                    varint_step(b, st);
                    if (st == VI_LONG)
                    begin
                        raise_error(pwfp_pkg::ERR_OVERLONG, lst, emit, res);
                    end
                    else if (st == VI_DONE)
                    begin
                        v = dec_acc;
                        dec_acc = '0;
                        dec_pos = '0;
                        if (v == 64'd0)
                        begin
                            dec_phase = pwfp_pkg::PH_TAG;
                            emit = 1'b1;
                            res = make_result(pwfp_pkg::KIND_HEADER, v, lst);
                        end
                        else if (lst)
                        begin
                            raise_error(pwfp_pkg::ERR_TRUNCATED, lst, emit, res);
                        end
                        else
                        begin
                            dec_remaining = v;
                            dec_phase = pwfp_pkg::PH_PAYLOAD;
                            emit = 1'b1;
                            res = make_result(pwfp_pkg::KIND_HEADER, v, lst);
                        end
                    end
                    else if (lst)
                    begin
                        raise_error(pwfp_pkg::ERR_TRUNCATED, lst, emit, res);
                    end
                end
                pwfp_pkg::PH_PAYLOAD:
                begin
                    dec_remaining = dec_remaining - 64'd1;
                    if (dec_remaining == 64'd0)
                    begin
                        dec_phase = pwfp_pkg::PH_TAG;
                        emit = 1'b1;
                        res = make_result(pwfp_pkg::KIND_PAYLOAD, {56'd0, b}, lst);
                    end
                    else if (lst)
                    begin
                        raise_error(pwfp_pkg::ERR_TRUNCATED, lst, emit, res);
                    end
                    else
                    begin
                        emit = 1'b1;
                        res = make_result(pwfp_pkg::KIND_PAYLOAD, {56'd0, b}, lst);
                    end
                end
                default:
                begin
                    dec_phase = pwfp_pkg::PH_TAG;
                    varint_step(b, st);
                    if (st == VI_LONG)
                    begin
                        raise_error(pwfp_pkg::ERR_OVERLONG, lst, emit, res);
                    end
                    else if (st == VI_DONE)
                    begin
                        v = dec_acc;
                        dec_acc = '0;
                        dec_pos = '0;
                        dec_wt = v[2:0];
                        dec_field = v[34:3];
                        if (dec_wt == pwfp_pkg::WT_GROUP_S || dec_wt == pwfp_pkg::WT_GROUP_E
                            || dec_wt > pwfp_pkg::WT_FIXED32)
                        begin
                            raise_error(pwfp_pkg::ERR_WIRE_TYPE, lst, emit, res);
                        end
                        else if (dec_field == 32'd0)
                        begin
                            raise_error(pwfp_pkg::ERR_FIELD_ZERO, lst, emit, res);
                        end
                        else if (lst)
                        begin
                            raise_error(pwfp_pkg::ERR_TRUNCATED, lst, emit, res);
                        end
                        else if (dec_wt == pwfp_pkg::WT_VARINT)
                        begin
                            dec_phase = pwfp_pkg::PH_VARINT;
                        end
                        else if (dec_wt == pwfp_pkg::WT_LENGTH)
                        begin
                            dec_phase = pwfp_pkg::PH_LENGTH;
                        end
                        else
                        begin
                            dec_phase = pwfp_pkg::PH_FIXED;
                        end
                    end
                    else if (lst)
                    begin
                        raise_error(pwfp_pkg::ERR_TRUNCATED, lst, emit, res);
                    end
                end
            endcase
        end
        if (lst)
        begin
            clear_decoder();
        end
    endtask

    task automatic push_varint(input logic [63:0] v, input int unsigned pad);
        int unsigned n;
        int unsigned total;
        int unsigned i;
        logic [63:0] s;
        logic [7:0]  b;
        n = 1;
        while (n < 10 && (v >> (7 * n)) != 64'd0)
        begin
            n++;
        end
        total = (n + pad > 10) ? 10 : n + pad;
        for (i = 0; i < total; i++)
        begin
            s = v >> (7 * i);
            b = {(i < total - 1), s[6:0]};
            if (i == 9 && $urandom_range(0, 3) == 0)
            begin
                b[6:1] = 6'($urandom_range(0, 63));
            end
            append_byte(b);
        end
    endtask

    task automatic build_message();
        int unsigned nfields;
        int unsigned f;
        int unsigned k;
        int unsigned len;
        int unsigned r;
        logic [31:0] fnum;
        logic [2:0]  wt;
        logic [63:0] tag;
        logic [63:0] v;
        msg_bytes.delete();
        if ($urandom_range(0, 19) == 0)
        begin
            len = $urandom_range(1, 12);
            for (k = 0; k < len; k++)
            begin
                append_byte(8'($urandom_range(0, 255)));
            end
            return;
        end
        nfields = $urandom_range(1, 5);
        for (f = 0; f < nfields; f++)
        begin
            case ($urandom_range(0, 9))
                0: fnum = $urandom;
                1: fnum = '1;
                default: fnum = $urandom_range(1, 40);
            endcase
            case ($urandom_range(0, 3))
                0: wt = pwfp_pkg::WT_VARINT;
                1: wt = pwfp_pkg::WT_FIXED64;
                2: wt = pwfp_pkg::WT_LENGTH;
                default: wt = pwfp_pkg::WT_FIXED32;
            endcase
            r = $urandom_range(0, 39);
            if (r == 0)
            begin
                wt = {1'b1, 2'($urandom_range(0, 3))};
                if (wt == pwfp_pkg::WT_FIXED32)
                begin
                    wt = pwfp_pkg::WT_GROUP_S;
                end
            end
            else if (r == 1)
            begin
                fnum = '0;
            end
            tag = {29'd0, fnum, wt};
            if ($urandom_range(0, 15) == 0)
            begin
                tag[63:35] = 29'($urandom);
            end
            push_varint(tag, pick_pad());
            case (wt)
                pwfp_pkg::WT_VARINT:
                begin
                    if ($urandom_range(0, 24) == 0)
                    begin
                        for (k = 0; k < 10; k++)
                        begin
                            append_byte({1'b1, 7'($urandom_range(0, 127))});
                        end
                        append_byte(8'($urandom_range(0, 255)));
                    end
                    else
                    begin
                        v = {$urandom, $urandom} >> $urandom_range(0, 63);
                        push_varint(v, pick_pad());
                    end
                end
                pwfp_pkg::WT_FIXED64:
                begin
                    for (k = 0; k < 8; k++)
                    begin
                        append_byte(8'($urandom_range(0, 255)));
                    end
                end
                pwfp_pkg::WT_FIXED32:
                begin
                    for (k = 0; k < 4; k++)
                    begin
                        append_byte(8'($urandom_range(0, 255)));
                    end
                end
                pwfp_pkg::WT_LENGTH:
                begin
                    if ($urandom_range(0, 24) == 0)
                    begin
                        v = {$urandom, $urandom} >> $urandom_range(0, 40);
                        push_varint(v, 0);
                        len = $urandom_range(1, 6);
                        for (k = 0; k < len; k++)
                        begin
                            append_byte(8'($urandom_range(0, 255)));
                        end
                        f = nfields;
                    end
                    else
                    begin
                        len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24)
                                                          : $urandom_range(0, 6);
                        push_varint(64'(len), pick_pad());
                        for (k = 0; k < len; k++)
                        begin
                            append_byte(8'($urandom_range(0, 255)));
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        if ($urandom_range(0, 5) == 0)
        begin
            k = $urandom_range(1, msg_bytes.size());
            while (msg_bytes.size() > k)
            begin
                void'(msg_bytes.pop_back());
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] data, input logic lst, input logic typed,
                             input pwfp_pkg::result_t want);
        int unsigned       gap;
        bit                emit;
        pwfp_pkg::result_t res;
        gap = pick_gap();
        if (gap != 0)
        begin
            byte_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_if.valid   <= 1'b1;
        byte_if.in_byte <= data;
        byte_if.last    <= lst;
        do
        begin
            @(posedge clk);
        end
        while (byte_if.ready !== 1'b1);
        decoded_items++;
        decode_byte(data, lst, emit, res);
        if (typed)
        begin
            queue_expected(want);
        end
        else if (emit)
        begin
            queue_expected(res);
        end
        @(negedge clk);
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(negedge clk)
    begin
        if (rx_hold != 0)
        begin
            field_if.ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end
        else
        begin
            field_if.ready <= 1'b1;
            rx_hold <= pick_gap();
        end
    end

    always @(posedge clk)
    begin : result_check
        pwfp_pkg::result_t got;
        pwfp_pkg::result_t want;
        if (rst_n && field_if.valid === 1'b1 && field_if.ready === 1'b1)
        begin
            got.kind          = field_if.kind;
            got.field_number  = field_if.field_number;
            got.wire_type     = field_if.wire_type;
            got.value         = field_if.value;
            got.end_of_buffer = field_if.end_of_buffer;
            if (expected_fields.size() == 0)
            begin
                $display("%0t: item with none expected, actual kind %0d field %0d value %0h",
                         $time, got.kind, got.field_number, got.value);
                mismatches++;
            end
            else
            begin
                want = expected_fields.pop_front();
                compare_field("kind", 64'(want.kind), 64'(got.kind));
                compare_field("field_number", 64'(want.field_number),
                              64'(got.field_number));
                compare_field("wire_type", 64'(want.wire_type), 64'(got.wire_type));
                compare_field("value", want.value, got.value);
                compare_field("end_of_buffer", 64'(want.end_of_buffer),
                              64'(got.end_of_buffer));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** protobuf_wire_field_parser: FAILED **");
            $finish;
        end
    end

    initial
    begin : stimulus
        int idx;
        int i;
        byte_if.valid   = 1'b0;
        byte_if.in_byte = 8'd0;
        byte_if.last    = 1'b0;
        field_if.ready  = 1'b0;
        clear_decoder();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        for (idx = 0; idx < DIRECTED_ROWS; idx++)
        begin
            send_byte(directed_rows[idx].data, directed_rows[idx].lst,
                      directed_rows[idx].typed, directed_rows[idx].want);
        end

        decoded_items = 0;
        while (decoded_items < RANDOM_ITEMS)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            build_message();
            for (i = 0; i < msg_bytes.size(); i++)
            begin
                send_byte(msg_bytes[i], i == msg_bytes.size() - 1, 1'b0, '0);
            end
        end
        byte_if.valid <= 1'b0;

        while (expected_fields.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_fields.size() == 0)
        begin
            $display("** protobuf_wire_field_parser: PASSED **");
        end
        else
        begin
            $display("** protobuf_wire_field_parser: FAILED **");
        end
        $finish;
    end

endmodule
